// File: rtl/npd_pkg.sv
// Shared constants, register and mode codes, and the lane type of the permutation core.
package npd_pkg;

  localparam int NODE_BITS  = 16;
  localparam int MAX_DIGITS = 16;
  localparam int CNT_W      = NODE_BITS + 1;
  localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);
  localparam int LOG_W      = $clog2(NODE_BITS + 1);
  localparam int MODE_W     = 3;
  localparam int DCNT_W     = 5;
  localparam int IDX_W      = 2;
  localparam int ADDR_W     = IDX_W + 2;
  localparam int DATA_W     = 32;
  localparam int LATENCY    = 1 + MAX_DIGITS * (NODE_BITS + 2);

  localparam logic [IDX_W-1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_NODE_COUNT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIGIT_RADIX  = 2'd2;
  localparam logic [IDX_W-1:0] REG_DIGIT_COUNT  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_BITCOMP   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BITREV    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHUFFLE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TORNADO   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NEIGHBOR  = 3'd5;

  localparam logic [MODE_W-1:0]  RST_PATTERN_MODE = MODE_BITCOMP;
  localparam logic [CNT_W-1:0]   RST_NODE_COUNT   = CNT_W'(64);
  localparam logic [CNT_W-1:0]   RST_DIGIT_RADIX  = CNT_W'(8);
  localparam logic [DCNT_W-1:0]  RST_DIGIT_COUNT  = DCNT_W'(2);

  typedef struct packed {
    logic                  oor;
    logic [LEFT_W-1:0]     left;
    logic [NODE_BITS-1:0]  quo;
    logic [CNT_W-1:0]      rem;
    logic [NODE_BITS-1:0]  res;
    logic [NODE_BITS-1:0]  wgt;
  } npd_lane_t;

endpackage

// File: rtl/npd_div_cell.sv
// One registered restoring-division step of the digit extraction chain.
module npd_div_cell import npd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] r_i,
  input  logic             vld_i,
  input  npd_lane_t        lane_i,
  output logic             vld_o,
  output npd_lane_t        lane_o
);

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           ge;
  logic           vld_q;
  npd_lane_t      lane_d;
  npd_lane_t      lane_q;

  always_comb begin
    trial      = {lane_i.rem, lane_i.quo[NODE_BITS-1]};
    diff       = trial - {1'b0, r_i};
    ge         = trial >= {1'b0, r_i};
    lane_d     = lane_i;
    lane_d.rem = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    lane_d.quo = {lane_i.quo[NODE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

// File: rtl/npd_digit_cell.sv
// One digit cell: a division by the radix, the digit remap, and the weighted accumulate.
module npd_digit_cell import npd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] r_i,
  input  logic [CNT_W-1:0] add_i,
  input  logic             vld_i,
  input  npd_lane_t        lane_i,
  output logic             vld_o,
  output npd_lane_t        lane_o
);

  logic                    vld_c [0:NODE_BITS];
  npd_lane_t               lane_c [0:NODE_BITS];
  logic [CNT_W:0]          dsum;
  logic [CNT_W:0]          dsub;
  npd_lane_t               map_d;
  npd_lane_t               map_q;
  logic                    map_vld_q;
  logic [NODE_BITS-1:0]    prod_res;
  logic [NODE_BITS-1:0]    prod_wgt;
  npd_lane_t               acc_d;
  npd_lane_t               acc_q;
  logic                    acc_vld_q;

  assign vld_c[0]  = vld_i;
  assign lane_c[0] = lane_i;

  for (genvar g = 0; g < NODE_BITS; g++) begin : g_step
    npd_div_cell u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .r_i    (r_i),
      .vld_i  (vld_c[g]),
      .lane_i (lane_c[g]),
      .vld_o  (vld_c[g+1]),
      .lane_o (lane_c[g+1])
    );
  end

  always_comb begin
    dsum      = {1'b0, lane_c[NODE_BITS].rem} + {1'b0, add_i};
    dsub      = dsum - {1'b0, r_i};
    map_d     = lane_c[NODE_BITS];
    map_d.rem = (dsum >= {1'b0, r_i}) ? dsub[CNT_W-1:0] : dsum[CNT_W-1:0];
  end

  always_comb begin
    prod_res  = map_q.wgt * map_q.rem[NODE_BITS-1:0];
    prod_wgt  = map_q.wgt * r_i[NODE_BITS-1:0];
    acc_d     = map_q;
    acc_d.rem = '0;
    if (map_q.left != '0) begin
      acc_d.res  = map_q.res + prod_res;
      acc_d.wgt  = prod_wgt;
      acc_d.left = map_q.left - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= 1'b0;
      acc_vld_q <= 1'b0;
    end else begin
      map_vld_q <= vld_c[NODE_BITS];
      acc_vld_q <= map_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    map_q <= map_d;
    acc_q <= acc_d;
  end

  assign vld_o  = acc_vld_q;
  assign lane_o = acc_q;

endmodule

// File: rtl/noc_permutation_destination_core.sv
// Top level of the permutation destination core: register port, front stage and digit chain.
// An accepted start reaches the result strobe through one front stage, then 16 digit cells
// of 16 division steps, a remap stage and an accumulate stage each.
// Throughput: one transaction per cycle; busy stays low and the result is never stalled.
// Reset clears the pipeline valid flags and returns the registers to bit complement,
// 64 nodes, radix 8 and two digits.
module noc_permutation_destination_core import npd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [NODE_BITS-1:0] source_node_i,
  output logic                 result_valid_o,
  output logic [NODE_BITS-1:0] dest_node_o,
  output logic                 out_of_range_o
);

  logic [MODE_W-1:0]    pattern_mode_q;
  logic [CNT_W-1:0]     node_count_q;
  logic [CNT_W-1:0]     digit_radix_q;
  logic [DCNT_W-1:0]    digit_count_q;
  logic                 cfg_wr;
  logic [IDX_W-1:0]     cfg_idx;

  logic                 accept;
  logic [LOG_W-1:0]     log_n;
  logic [LOG_W-1:0]     half;
  logic [CNT_W-1:0]     mask;
  logic [NODE_BITS-1:0] lo;
  logic [NODE_BITS-1:0] rev;
  logic [CNT_W-1:0]     sh;
  logic [CNT_W-1:0]     radix_eff;
  logic [CNT_W:0]       rp1;
  logic [CNT_W-1:0]     add_val;
  logic                 oor;
  npd_lane_t            front_d;
  npd_lane_t            front_q;
  logic                 front_vld_q;

  logic                 vld_c [0:MAX_DIGITS];
  npd_lane_t            lane_c [0:MAX_DIGITS];

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q <= RST_PATTERN_MODE;
      node_count_q   <= RST_NODE_COUNT;
      digit_radix_q  <= RST_DIGIT_RADIX;
      digit_count_q  <= RST_DIGIT_COUNT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_MODE: pattern_mode_q <= pwdata[MODE_W-1:0];
        REG_NODE_COUNT:   node_count_q   <= pwdata[CNT_W-1:0];
        REG_DIGIT_RADIX:  digit_radix_q  <= pwdata[CNT_W-1:0];
        REG_DIGIT_COUNT:  digit_count_q  <= pwdata[DCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_MODE: prdata = DATA_W'(pattern_mode_q);
      REG_NODE_COUNT:   prdata = DATA_W'(node_count_q);
      REG_DIGIT_RADIX:  prdata = DATA_W'(digit_radix_q);
      REG_DIGIT_COUNT:  prdata = DATA_W'(digit_count_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    log_n = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (node_count_q[i]) begin
        log_n = LOG_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NODE_BITS; i++) begin
      rev[i] = source_node_i[NODE_BITS-1-i];
    end
  end

  always_comb begin
    mask      = node_count_q - 1'b1;
    half      = log_n >> 1;
    lo        = ~({NODE_BITS{1'b1}} << half);
    sh        = {source_node_i, 1'b0};
    radix_eff = (digit_radix_q == '0) ? CNT_W'(1) : digit_radix_q;
    rp1       = {1'b0, radix_eff} + 1'b1;
    add_val   = (pattern_mode_q == MODE_TORNADO) ? (rp1[CNT_W:1] - 1'b1) : CNT_W'(1);
    oor       = {1'b0, source_node_i} >= node_count_q;

    front_d      = '0;
    front_d.oor  = oor;
    front_d.quo  = source_node_i;
    front_d.wgt  = NODE_BITS'(1);
    case (pattern_mode_q)
      MODE_BITCOMP:   front_d.res = ~source_node_i & mask[NODE_BITS-1:0];
      MODE_TRANSPOSE: front_d.res = ((source_node_i >> half) & lo)
                                  | ((source_node_i << half) & (lo << half));
      MODE_BITREV:    front_d.res = rev >> (LOG_W'(NODE_BITS) - log_n);
      MODE_SHUFFLE:   front_d.res = (sh[NODE_BITS-1:0] & mask[NODE_BITS-1:0])
                                  | NODE_BITS'(|(sh & node_count_q));
      MODE_TORNADO, MODE_NEIGHBOR: begin
        if (int'(digit_count_q) > MAX_DIGITS) begin
          front_d.left = LEFT_W'(MAX_DIGITS);
        end else begin
          front_d.left = LEFT_W'(digit_count_q);
        end
      end
      default:        front_d.res = '0;
    endcase
    if (oor) begin
      front_d.res  = '0;
      front_d.left = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else begin
      front_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign vld_c[0]  = front_vld_q;
  assign lane_c[0] = front_q;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
    npd_digit_cell u_digit (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .r_i    (radix_eff),
      .add_i  (add_val),
      .vld_i  (vld_c[g]),
      .lane_i (lane_c[g]),
      .vld_o  (vld_c[g+1]),
      .lane_o (lane_c[g+1])
    );
  end

  assign result_valid_o = vld_c[MAX_DIGITS];
  assign dest_node_o    = lane_c[MAX_DIGITS].res;
  assign out_of_range_o = lane_c[MAX_DIGITS].oor;

  // Every accepted transaction yields its result strobe once it has passed through the whole pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY result_valid_o)
    else $error("result strobe missing after pipeline latency");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |-> (dest_node_o == '0))
    else $error("out-of-range result carries a nonzero destination");

  a_oor_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ({1'b0, source_node_i} >= node_count_q)) |-> ##LATENCY
    (result_valid_o && out_of_range_o))
    else $error("out-of-range source not flagged");

  a_in_range_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ({1'b0, source_node_i} < node_count_q)) |-> ##LATENCY
    (result_valid_o && !out_of_range_o))
    else $error("in-range source flagged as out of range");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the permutation destination core: register setup, traffic and checks.
`timescale 1ns / 1ps

module tb;
  import npd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE  = 3'd7;
  localparam int                RAND_ITEMS  = 1250;
  localparam int                STALL_LIMIT = 8 * LATENCY;

  typedef struct packed {
    logic [NODE_BITS-1:0] dest;
    logic                 oor;
  } route_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [ADDR_W-1:0]    paddr          = '0;
  logic [DATA_W-1:0]    pwdata         = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [NODE_BITS-1:0] source_node_i  = '0;
  logic                 result_valid_o;
  logic [NODE_BITS-1:0] dest_node_o;
  logic                 out_of_range_o;

  logic [MODE_W-1:0]    cfg_mode   = RST_PATTERN_MODE;
  logic [CNT_W-1:0]     cfg_nodes  = RST_NODE_COUNT;
  logic [CNT_W-1:0]     cfg_radix  = RST_DIGIT_RADIX;
  logic [DCNT_W-1:0]    cfg_digits = RST_DIGIT_COUNT;

  logic [NODE_BITS-1:0] source_q[$];
  route_t               route_q[$];
  bit                   gaps_on    = 1'b1;
  int                   gap_cnt    = 0;
  int                   stall_cnt  = 0;
  int                   fail_cnt   = 0;

  noc_permutation_destination_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .source_node_i  (source_node_i),
    .result_valid_o (result_valid_o),
    .dest_node_o    (dest_node_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    if (fail_cnt < 10) begin
      $display("%0t: %s", $time, msg);
    end
    fail_cnt++;
  endtask

  function automatic logic [NODE_BITS-1:0] digit_remap(input logic [NODE_BITS-1:0] src,
                                                        input bit tornado);
    longint unsigned r, add, wgt, q, d, acc, span;
    bit              past;
    int              n, i;
    r    = (cfg_radix == 0) ? 64'd1 : 64'(cfg_radix);
    add  = tornado ? (r + 1) / 2 - 1 : 64'd1;
    span = 64'd1 << NODE_BITS;
    wgt  = 1;
    acc  = 0;
    past = 1'b0;
    n    = (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : int'(cfg_digits);
    for (i = 0; i < n; i++) begin
      q = past ? 64'd0 : 64'(src) / wgt;
      d = ((q % r) + add) % r;
      acc += wgt * d;
      if (!past && wgt > span / r) begin
        past = 1'b1;
      end
      wgt *= r;
    end
    return acc[NODE_BITS-1:0];
  endfunction

  function automatic route_t predict_route(input logic [NODE_BITS-1:0] src);
    route_t          p;
    logic [63:0]     s, d, lo, sh;
    longint unsigned nc, tmp;
    int              lg, h, i;
    s  = 64'(src);
    nc = 64'(cfg_nodes);
    d  = '0;
    lg = 0;
    tmp = nc;
    while (tmp > 1) begin
      tmp >>= 1;
      lg++;
    end
    if (s >= nc) begin
      p.dest = '0;
      p.oor  = 1'b1;
      return p;
    end
    case (cfg_mode)
      MODE_BITCOMP: d = ~s & (nc - 1);
      MODE_TRANSPOSE: begin
        h  = lg / 2;
        lo = (64'd1 << h) - 1;
        d  = ((s >> h) & lo) | ((s << h) & (lo << h));
      end
      MODE_BITREV: begin
        for (i = 0; i < lg; i++) begin
          d = {d[62:0], s[i]};
        end
      end
      MODE_SHUFFLE: begin
        sh = s << 1;
        d  = (sh & (nc - 1)) | 64'((sh & nc) != 0);
      end
      MODE_TORNADO:  d = 64'(digit_remap(src, 1'b1));
      MODE_NEIGHBOR: d = 64'(digit_remap(src, 1'b0));
      default:       d = '0;
    endcase
    p.dest = d[NODE_BITS-1:0];
    p.oor  = 1'b0;
    return p;
  endfunction

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] nc,
                            input logic [CNT_W-1:0] rdx, input logic [DCNT_W-1:0] dc);
    while (source_q.size() != 0 || route_q.size() != 0) @(posedge clk_i);
    reg_write(REG_PATTERN_MODE, DATA_W'(m));
    reg_write(REG_NODE_COUNT, DATA_W'(nc));
    reg_write(REG_DIGIT_RADIX, DATA_W'(rdx));
    reg_write(REG_DIGIT_COUNT, DATA_W'(dc));
    cfg_mode   = m;
    cfg_nodes  = nc;
    cfg_radix  = rdx;
    cfg_digits = dc;
    @(posedge clk_i);
  endtask

  function automatic logic [CNT_W-1:0] extreme_count();
    case ($urandom_range(0, 4))
      0:       return CNT_W'(0);
      1:       return CNT_W'(1);
      2:       return CNT_W'(2);
      3:       return CNT_W'(65536);
      default: return CNT_W'(131071);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (gap_cnt != 0) begin
      start   <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      start   <= 1'b0;
      gap_cnt <= $urandom_range(0, 13);
    end else if (source_q.size() != 0) begin
      start         <= 1'b1;
      source_node_i <= source_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    route_t want;
    bit     active;
    active = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        active = 1'b1;
        if (route_q.size() == 0) begin
          report($sformatf("unexpected result: dest %0d oor %0b", dest_node_o, out_of_range_o));
        end else begin
          want = route_q.pop_front();
          if (dest_node_o !== want.dest || out_of_range_o !== want.oor) begin
            report($sformatf("mismatch: dest %0d oor %0b, expected dest %0d oor %0b",
                             dest_node_o, out_of_range_o, want.dest, want.oor));
          end
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        route_q.insert(route_q.size(), predict_route(source_node_i));
        void'(source_q.pop_front());
      end
      if (psel && penable && pwrite && pready) begin
        active = 1'b1;
      end
      if (active) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0]    m;
    logic [CNT_W-1:0]     nc, rdx;
    logic [DCNT_W-1:0]    dc;
    logic [NODE_BITS-1:0] s;
    int                   n, sent, k;
    int unsigned          span;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    source_q = '{16'd0, 16'd63, 16'd64, 16'hFFFF};
    set_config(MODE_TRANSPOSE, 17'd65536, 17'd8, 5'd2);
    source_q = '{16'hFFFF, 16'h00FF, 16'h1234};
    set_config(MODE_TRANSPOSE, 17'd32, 17'd8, 5'd2);
    source_q = '{16'd31, 16'd22};
    set_config(MODE_BITREV, 17'd65536, 17'd8, 5'd2);
    source_q = '{16'h0001, 16'h8000};
    set_config(MODE_SHUFFLE, 17'd100, 17'd8, 5'd2);
    source_q = '{16'd99, 16'd50};
    set_config(MODE_TORNADO, 17'd64, 17'd8, 5'd2);
    source_q = '{16'd0, 16'd63};
    set_config(MODE_NEIGHBOR, 17'd65536, 17'd65536, 5'd16);
    source_q = '{16'hFFFF, 16'd0};
    set_config(MODE_SPARE, 17'd64, 17'd8, 5'd2);
    source_q = '{16'd5};
    set_config(MODE_TORNADO, 17'd65536, 17'd0, 5'd4);
    source_q = '{16'd10};
    set_config(MODE_NEIGHBOR, 17'd65536, 17'd2, 5'd31);
    source_q = '{16'hAAAA};
    set_config(MODE_NEIGHBOR, 17'd64, 17'd8, 5'd0);
    source_q = '{16'd7};
    set_config(MODE_BITCOMP, 17'd0, 17'd8, 5'd2);
    source_q = '{16'd0};
    set_config(MODE_BITCOMP, 17'd131071, 17'd131071, 5'd3);
    source_q = '{16'hFFFF};

    sent = 0;
    while (sent < RAND_ITEMS) begin
      m = ($urandom_range(0, 12) == 0) ? MODE_W'($urandom_range(6, 7))
                                       : MODE_W'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0:       nc = extreme_count();
        1, 2:    nc = CNT_W'($urandom_range(0, 131071));
        default: nc = CNT_W'(1) << $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 5))
        0:       rdx = extreme_count();
        1:       rdx = CNT_W'($urandom_range(0, 131071));
        default: rdx = CNT_W'($urandom_range(2, 16));
      endcase
      dc = ($urandom_range(0, 4) == 0) ? DCNT_W'($urandom_range(0, 31))
                                       : DCNT_W'($urandom_range(1, 6));
      set_config(m, nc, rdx, dc);
      n = $urandom_range(10, 60);
      if (n > RAND_ITEMS - sent) begin
        n = RAND_ITEMS - sent;
      end
      gaps_on = (RAND_ITEMS - sent > 150) ? ($urandom_range(0, 3) != 0) : 1'b0;
      span = (cfg_nodes > 65536) ? 65536 : cfg_nodes;
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0:       s = NODE_BITS'($urandom());
          1:       s = (span == 0) ? '0 : NODE_BITS'(span - 1);
          2:       s = '0;
          3:       s = '1;
          default: s = (span == 0) ? NODE_BITS'($urandom())
                                   : NODE_BITS'($urandom_range(0, span - 1));
        endcase
        source_q.insert(source_q.size(), s);
      end
      sent += n;
    end

    while (source_q.size() != 0 || route_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 16) @(posedge clk_i);
    if (route_q.size() != 0) begin
      report($sformatf("%0d results never arrived", route_q.size()));
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
